// ===== rtl/gno_pkg.sv =====
// Shared types, widths, hash constants and the sine table generator for the
// fractal gradient noise block. No dependencies.
package gno_pkg;

	localparam int MAX_OCTAVES_DEF = 8;
	localparam int ANGLE_BITS_DEF  = 10;

	localparam int COORD_W    = 32;
	localparam int FRAC_W     = 16;
	localparam int DOT_W      = 34;
	localparam int P_W        = 19;
	localparam int AMP_W      = 40;
	localparam int AMP_LO_W   = 24;
	localparam int WGT_W      = 45;
	localparam int TOT_W      = 64;
	localparam int QUO_W      = 18;
	localparam int OUT_W      = 16;
	localparam int CNT_W      = 4;
	localparam int PERS_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OCT_IDX_W  = 5;

	localparam logic [31:0] HASH_MUL_A  = 32'd3284157443;
	localparam logic [31:0] HASH_MUL_B  = 32'd1911520717;
	localparam logic [31:0] HASH_MUL_C  = 32'd2048419325;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	localparam logic [AMP_W-1:0]      AMP_INIT = 40'd4096;
	localparam logic signed [P_W-1:0] P_BIAS   = 19'sd32768;
	localparam logic [OUT_W-1:0]      OUT_MAX  = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 2'd1;

	localparam logic [CNT_W-1:0]  OCT_CNT_RST = 4'd1;
	localparam logic [PERS_W-1:0] PERS_RST    = 16'd2048;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [TOT_W-1:0]   total;
		logic [WGT_W-1:0]          weight;
		logic [AMP_W-1:0]          amp;
	} oct_bus_t;

	typedef struct packed {
		logic [TOT_W-1:0] rem;
		logic [WGT_W-1:0] weight;
		logic [QUO_W-1:0] quo;
		logic             nonpos;
	} div_bus_t;

	function automatic logic [31:0] rot16(input logic [31:0] v);
		rot16 = {v[15:0], v[31:16]};
	endfunction

	// Raise a series term by two powers of the angle, Q2.30.
	function automatic logic [63:0] series_step(input logic [63:0] term,
		input logic [63:0] t);
		series_step = (((term * t) >> 30) * t) >> 30;
	endfunction

	// Quarter-wave sine entry q of a table with 2^(ab-2) steps, Q1.15.
	// Evaluated at elaboration only.
	function automatic logic [15:0] sine_entry(input int unsigned q, input int unsigned ab);
		logic [63:0] t;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] r;
		t = (64'(q) * 64'(HALF_PI_Q30)) >> (ab - 2);
		term = t;
		sum = $signed(t);
		term = series_step(term, t) / 64'd6;
		sum = sum - $signed(term);
		term = series_step(term, t) / 64'd20;
		sum = sum + $signed(term);
		term = series_step(term, t) / 64'd42;
		sum = sum - $signed(term);
		term = series_step(term, t) / 64'd72;
		sum = sum + $signed(term);
		term = series_step(term, t) / 64'd110;
		sum = sum - $signed(term);
		term = series_step(term, t) / 64'd156;
		sum = sum + $signed(term);
		term = series_step(term, t) / 64'd210;
		sum = sum - $signed(term);
		term = series_step(term, t) / 64'd272;
		sum = sum + $signed(term);
		if (sum < 0)
			sum = 0;
		r = (sum + 64'sd16384) >>> 15;
		sine_entry = (r > 64'sd32767) ? 16'd32767 : r[15:0];
	endfunction

endpackage

// ===== rtl/gno_octave_cell.sv =====
// One octave of the noise chain: lattice hash, gradient lookup, dot products,
// bilinear blend and weighted accumulation, nine pipeline stages.
// Depends on gno_pkg.
module gno_octave_cell #(
	parameter int K = 0,
	parameter int ANGLE_BITS = gno_pkg::ANGLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_vld,
	input  gno_pkg::oct_bus_t               in_bus,
	input  logic [gno_pkg::OCT_IDX_W-1:0]   oct_cnt,
	input  logic [gno_pkg::PERS_W-1:0]      pers,
	output logic                            out_vld,
	output gno_pkg::oct_bus_t               out_bus
);

	localparam int QUARTER = 1 << (ANGLE_BITS - 2);
	localparam int RIDX_W  = ANGLE_BITS - 1;
	localparam int DW      = gno_pkg::DOT_W;
	localparam int PW      = gno_pkg::P_W;
	localparam int LO_W    = gno_pkg::AMP_LO_W;
	localparam int AW      = gno_pkg::AMP_W;

	logic [15:0] sin_rom [QUARTER+1];

	for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
		localparam logic [15:0] SV = gno_pkg::sine_entry(g, ANGLE_BITS);
		assign sin_rom[g] = SV;
	end

	function automatic logic signed [15:0] sin_at(input logic [ANGLE_BITS-1:0] idx);
		logic [RIDX_W-1:0] ri;
		logic [RIDX_W-1:0] rm;
		logic [15:0] mag;
		ri = RIDX_W'(idx[ANGLE_BITS-3:0]);
		rm = RIDX_W'(QUARTER) - ri;
		mag = idx[ANGLE_BITS-2] ? sin_rom[rm] : sin_rom[ri];
		sin_at = idx[ANGLE_BITS-1] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [DW-1:0] blend(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b, input logic [15:0] s);
		logic signed [DW:0] d;
		logic signed [DW+17:0] m;
		d = {b[DW-1], b} - {a[DW-1], a};
		m = d * $signed({1'b0, s});
		blend = a + DW'(m >>> 16);
	endfunction

	function automatic logic [AW-1:0] next_amp(input logic [AW-1:0] amp,
		input logic [gno_pkg::PERS_W-1:0] p);
		logic [AW+15:0] prod;
		logic [AW+3:0] sh;
		prod = amp * p;
		sh = prod[AW+15:12];
		next_amp = (|sh[AW+3:AW]) ? {AW{1'b1}} : sh[AW-1:0];
	endfunction

	// Stage 0: scale by 2^K and split into lattice corner and fraction.
	logic signed [63:0] xs_c;
	logic signed [63:0] ys_c;
	logic [31:0] ix_c;
	logic [31:0] iy_c;

	always_comb begin
		xs_c = 64'(in_bus.x) <<< K;
		ys_c = 64'(in_bus.y) <<< K;
		ix_c = xs_c[47:16];
		iy_c = ys_c[47:16];
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	gno_pkg::oct_bus_t bus_s1, bus_s2, bus_s3, bus_s4, bus_s5, bus_s6, bus_s7;
	gno_pkg::oct_bus_t bus_s8, bus_s9, bus_nxt;
	logic [15:0] fx_s1, fx_s2, fx_s3, fx_s4, fx_s5;
	logic [15:0] fy_s1, fy_s2, fy_s3, fy_s4, fy_s5, fy_s6;
	logic [31:0] a_s1 [2];
	logic [31:0] iy_s1 [2];
	logic [31:0] a_s2 [4];
	logic [31:0] b_s2 [4];
	logic [ANGLE_BITS-1:0] idx_s3 [4];
	logic signed [15:0] gx_s4 [4];
	logic signed [15:0] gy_s4 [4];
	logic signed [DW-1:0] dot_s5 [4];
	logic signed [DW-1:0] top_s6;
	logic signed [DW-1:0] bot_s6;
	logic signed [DW-1:0] v_c;
	logic signed [PW-1:0] p_s7;
	logic signed [PW+LO_W:0] pp_lo_s8;
	logic signed [PW+AW-LO_W:0] pp_hi_s8;
	logic [AW-1:0] amp_nx_s8;
	logic active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		a_s1[0]  <= ix_c * gno_pkg::HASH_MUL_A;
		a_s1[1]  <= (ix_c + 32'd1) * gno_pkg::HASH_MUL_A;
		iy_s1[0] <= iy_c;
		iy_s1[1] <= iy_c + 32'd1;
		fx_s1    <= xs_c[15:0];
		fy_s1    <= ys_c[15:0];
		bus_s1   <= in_bus;

		fx_s2 <= fx_s1;
		fx_s3 <= fx_s2;
		fx_s4 <= fx_s3;
		fx_s5 <= fx_s4;
		fy_s2 <= fy_s1;
		fy_s3 <= fy_s2;
		fy_s4 <= fy_s3;
		fy_s5 <= fy_s4;
		fy_s6 <= fy_s5;
		bus_s2 <= bus_s1;
		bus_s3 <= bus_s2;
		bus_s4 <= bus_s3;
		bus_s5 <= bus_s4;
		bus_s6 <= bus_s5;
		bus_s7 <= bus_s6;
		bus_s8 <= bus_s7;
		bus_s9 <= bus_nxt;

		top_s6 <= blend(dot_s5[0], dot_s5[1], fx_s5);
		bot_s6 <= blend(dot_s5[2], dot_s5[3], fx_s5);
		p_s7   <= PW'(v_c >>> 16) + gno_pkg::P_BIAS;

		pp_lo_s8  <= p_s7 * $signed({1'b0, bus_s7.amp[LO_W-1:0]});
		pp_hi_s8  <= p_s7 * $signed({1'b0, bus_s7.amp[AW-1:LO_W]});
		amp_nx_s8 <= next_amp(bus_s7.amp, pers);
	end

	assign v_c = blend(top_s6, bot_s6, fy_s6);

	// Corner c: bit 0 selects x0/x1, bit 1 selects y0/y1.
	for (genvar c = 0; c < 4; c++) begin : g_corner
		localparam int CX = c % 2;
		localparam int CY = c / 2;
		logic [31:0] hash_c;
		logic signed [16:0] dx_c;
		logic signed [16:0] dy_c;

		assign hash_c = (a_s2[c] ^ gno_pkg::rot16(b_s2[c])) * gno_pkg::HASH_MUL_C;
		assign dx_c = (CX == 1) ? $signed({1'b1, fx_s4}) : $signed({1'b0, fx_s4});
		assign dy_c = (CY == 1) ? $signed({1'b1, fy_s4}) : $signed({1'b0, fy_s4});

		always_ff @(posedge clk) begin
			a_s2[c]   <= a_s1[CX];
			b_s2[c]   <= (iy_s1[CY] ^ gno_pkg::rot16(a_s1[CX])) * gno_pkg::HASH_MUL_B;
			idx_s3[c] <= hash_c[31:32-ANGLE_BITS];
			gx_s4[c]  <= sin_at(idx_s3[c] + ANGLE_BITS'(QUARTER));
			gy_s4[c]  <= sin_at(idx_s3[c]);
			dot_s5[c] <= dx_c * gx_s4[c] + dy_c * gy_s4[c];
		end
	end

	// Add this octave only when it lies below the configured count.
	assign active = gno_pkg::OCT_IDX_W'(K) < oct_cnt;

	always_comb begin
		bus_nxt = bus_s8;
		bus_nxt.amp = amp_nx_s8;
		if (active) begin
			bus_nxt.total = bus_s8.total + gno_pkg::TOT_W'(pp_lo_s8)
				+ (gno_pkg::TOT_W'(pp_hi_s8) <<< LO_W);
			bus_nxt.weight = bus_s8.weight + gno_pkg::WGT_W'(bus_s8.amp);
		end
	end

	assign out_vld = vld_s9;
	assign out_bus = bus_s9;

endmodule

// ===== rtl/gno_div_cell.sv =====
// One restoring-division step: decides quotient bit BIT of total / weight.
// Depends on gno_pkg.
module gno_div_cell #(
	parameter int BIT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  gno_pkg::div_bus_t in_bus,
	output logic              out_vld,
	output gno_pkg::div_bus_t out_bus
);

	logic [gno_pkg::TOT_W-1:0] dvs_c;
	logic                      ge_c;
	gno_pkg::div_bus_t         bus_s1;
	logic                      vld_s1;

	assign dvs_c = gno_pkg::TOT_W'(in_bus.weight) << BIT;
	assign ge_c  = in_bus.rem >= dvs_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		bus_s1 <= in_bus;
		if (ge_c) begin
			bus_s1.rem <= in_bus.rem - dvs_c;
			bus_s1.quo[BIT] <= 1'b1;
		end
	end

	assign out_vld = vld_s1;
	assign out_bus = bus_s1;

endmodule

// ===== rtl/gradient_noise_octaves.sv =====
// Top level of the fractal gradient noise block: configuration registers,
// the chain of octave cells and the divider chain. Depends on gno_pkg,
// gno_octave_cell and gno_div_cell.

// One sample transaction is taken on every clock in which start is high; busy
// stays low, so points may stream back to back with no gaps. Each transaction
// returns exactly one noise_value, flagged by done for one cycle, after it has
// passed through nine stages for each octave cell in the chain, eighteen for
// the divider that forms one quotient bit per stage, and one output register.
// The receiver cannot hold results off, so capture done and noise_value in the
// same cycle. Octave cells always run, one per possible octave; octaves at or
// beyond the configured count pass their sums through untouched. Write the
// configuration registers only while no transaction is in flight.
module gradient_noise_octaves #(
	parameter int MAX_OCTAVES = gno_pkg::MAX_OCTAVES_DEF,
	parameter int ANGLE_BITS  = gno_pkg::ANGLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gno_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [gno_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [gno_pkg::COORD_W-1:0] x_coord,
	input  logic signed [gno_pkg::COORD_W-1:0] y_coord,
	output logic                              done,
	output logic [gno_pkg::OUT_W-1:0]         noise_value
);

	localparam int QW = gno_pkg::QUO_W;

	logic [gno_pkg::CNT_W-1:0]     octave_count_q;
	logic [gno_pkg::PERS_W-1:0]    persistence_q;
	logic [gno_pkg::OCT_IDX_W-1:0] oct_eff;

	// Configuration writes; unknown indexes drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= gno_pkg::OCT_CNT_RST;
			persistence_q  <= gno_pkg::PERS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				gno_pkg::REG_OCTAVE_COUNT: octave_count_q <= cfg_wdata[gno_pkg::CNT_W-1:0];
				gno_pkg::REG_PERSISTENCE:  persistence_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp the octave count to the number of cells in the chain.
	assign oct_eff = (octave_count_q > MAX_OCTAVES) ? gno_pkg::OCT_IDX_W'(MAX_OCTAVES)
		: gno_pkg::OCT_IDX_W'(octave_count_q);

	assign busy = 1'b0;

	// Octave chain: each cell adds its weighted octave and hands the sums on.
	logic              oct_vld [MAX_OCTAVES+1];
	gno_pkg::oct_bus_t oct_bus [MAX_OCTAVES+1];

	assign oct_vld[0] = start && !busy;
	always_comb begin
		oct_bus[0].x      = x_coord;
		oct_bus[0].y      = y_coord;
		oct_bus[0].total  = '0;
		oct_bus[0].weight = '0;
		oct_bus[0].amp    = gno_pkg::AMP_INIT;
	end

	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
		gno_octave_cell #(
			.K(k),
			.ANGLE_BITS(ANGLE_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_vld(oct_vld[k]),
			.in_bus(oct_bus[k]),
			.oct_cnt(oct_eff),
			.pers(persistence_q),
			.out_vld(oct_vld[k+1]),
			.out_bus(oct_bus[k+1])
		);
	end

	// Divider chain: the weighted mean stays below 2^17, so eighteen quotient
	// bits cover it; a sum at or below zero yields zero.
	logic              div_vld [QW+1];
	gno_pkg::div_bus_t div_bus [QW+1];

	assign div_vld[0] = oct_vld[MAX_OCTAVES];
	always_comb begin
		div_bus[0].rem    = oct_bus[MAX_OCTAVES].total;
		div_bus[0].weight = oct_bus[MAX_OCTAVES].weight;
		div_bus[0].quo    = '0;
		div_bus[0].nonpos = oct_bus[MAX_OCTAVES].total <= 64'sd0;
	end

	for (genvar i = 0; i < QW; i++) begin : g_div
		gno_div_cell #(
			.BIT(QW - 1 - i)
		) u_div (
			.clk(clk),
			.arst_n(arst_n),
			.in_vld(div_vld[i]),
			.in_bus(div_bus[i]),
			.out_vld(div_vld[i+1]),
			.out_bus(div_bus[i+1])
		);
	end

	// Output register: saturate the quotient to the 16-bit range.
	logic                      done_q;
	logic [gno_pkg::OUT_W-1:0] noise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= div_vld[QW];
	end

	always_ff @(posedge clk) begin
		if (div_bus[QW].nonpos)
			noise_q <= '0;
		else if (|div_bus[QW].quo[QW-1:gno_pkg::OUT_W])
			noise_q <= gno_pkg::OUT_MAX;
		else
			noise_q <= div_bus[QW].quo[gno_pkg::OUT_W-1:0];
	end

	assign done        = done_q;
	assign noise_value = noise_q;

`ifndef SYNTHESIS
	a_weight_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(oct_vld[MAX_OCTAVES] && oct_bus[MAX_OCTAVES].total > 64'sd0)
		|-> (oct_bus[MAX_OCTAVES].weight != '0))
		else $error("positive octave sum with zero weight");

	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(oct_vld[MAX_OCTAVES] && oct_bus[MAX_OCTAVES].total > 64'sd0)
		|-> (gno_pkg::TOT_W'(oct_bus[MAX_OCTAVES].total)
			< (gno_pkg::TOT_W'(oct_bus[MAX_OCTAVES].weight) << QW)))
		else $error("weighted mean exceeds divider range");

	a_nonpos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld[QW] && div_bus[QW].nonpos) |=> (done && noise_value == '0))
		else $error("non-positive sum did not give zero");
`endif

endmodule

// ===== tb/sv/gradient_noise_octaves_test.sv =====
// Self-checking testbench for gradient_noise_octaves: drives sample transactions
// and register writes, predicts fractal noise per point and compares every done strobe.
// Depends on gno_pkg and the gradient_noise_octaves RTL.
module gradient_noise_octaves_test;

	localparam int QUARTER_STEPS = 1 << (gno_pkg::ANGLE_BITS_DEF - 2);
	localparam int ANGLE_MASK    = (1 << gno_pkg::ANGLE_BITS_DEF) - 1;
	// cycles to sit idle before a register write: covers the full pipeline
	localparam int IDLE_CYCLES   = 9 * gno_pkg::MAX_OCTAVES_DEF + 19 + 10;
	localparam int WATCHDOG_MAX  = 4000;

	typedef enum logic [1:0] {IT_SAMPLE, IT_WRITE, IT_DRAIN} item_kind_t;

	typedef struct {
		item_kind_t                          kind;
		logic [gno_pkg::COORD_W-1:0]         x;
		logic [gno_pkg::COORD_W-1:0]         y;
		logic [gno_pkg::CFG_IDX_W-1:0]       idx;
		logic [gno_pkg::CFG_DATA_W-1:0]      data;
		int                                  max_gap;
	} stim_item_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [gno_pkg::CFG_IDX_W-1:0]      cfg_idx = '0;
	logic [gno_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
	logic                               start = 1'b0;
	logic                               busy;
	logic signed [gno_pkg::COORD_W-1:0] x_coord = '0;
	logic signed [gno_pkg::COORD_W-1:0] y_coord = '0;
	logic                               done;
	logic [gno_pkg::OUT_W-1:0]          noise_value;

	stim_item_t                pending_items[$];
	logic [gno_pkg::OUT_W-1:0] noise_expected[$];
	longint                    sine_quarter[0:QUARTER_STEPS];
	int unsigned               octaves_cfg = 1;
	int unsigned               persist_cfg = 2048;
	int                        fails = 0;
	int                        quiet_cycles = 0;
	int                        gap_left = 0;
	int                        stall_cycles = 0;

	gradient_noise_octaves u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .start(start), .busy(busy), .x_coord(x_coord),
		.y_coord(y_coord), .done(done), .noise_value(noise_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Quarter-wave table from a truncated Taylor series, Q1.15, same rounding as the block.
	initial begin
		longint unsigned t, term;
		longint sum;
		for (int q = 0; q <= QUARTER_STEPS; q++) begin
			t = (longint'(q) * longint'(gno_pkg::HALF_PI_Q30)) / QUARTER_STEPS;
			term = t;
			sum = longint'(t);
			for (int n = 1; n <= 8; n++) begin
				term = ((((term * t) >> 30) * t) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					sum -= longint'(term);
				else
					sum += longint'(term);
			end
			if (sum < 0)
				sum = 0;
			sum = (sum + 16384) >>> 15;
			sine_quarter[q] = (sum > 32767) ? 32767 : sum;
		end
	end

	function automatic longint sine_of(int unsigned idx);
		int unsigned quad, r;
		quad = (idx & ANGLE_MASK) >> (gno_pkg::ANGLE_BITS_DEF - 2);
		r = idx & (QUARTER_STEPS - 1);
		case (quad)
			0: return sine_quarter[r];
			1: return sine_quarter[QUARTER_STEPS - r];
			2: return -sine_quarter[r];
			default: return -sine_quarter[QUARTER_STEPS - r];
		endcase
	endfunction

	function automatic logic [31:0] lattice_hash(logic [31:0] ix, logic [31:0] iy);
		logic [31:0] a, b;
		a = ix * gno_pkg::HASH_MUL_A;
		b = iy ^ {a[15:0], a[31:16]};
		b = b * gno_pkg::HASH_MUL_B;
		a = a ^ {b[15:0], b[31:16]};
		return a * gno_pkg::HASH_MUL_C;
	endfunction

	function automatic longint gradient_dot(logic [31:0] cx, logic [31:0] cy,
			longint dx, longint dy);
		int unsigned idx;
		idx = lattice_hash(cx, cy) >> (32 - gno_pkg::ANGLE_BITS_DEF);
		return dx * sine_of((idx + QUARTER_STEPS) & ANGLE_MASK) + dy * sine_of(idx);
	endfunction

	function automatic longint lerp_q16(longint a, longint b, longint s);
		return a + (((b - a) * s) >>> 16);
	endfunction

	// Noise of one octave in Q.16, biased by one half and left unclamped.
	function automatic longint octave_noise(longint x, longint y, int k);
		longint xs, ys, fx, fy, top, bot;
		logic [31:0] x0, y0;
		xs = x <<< k;
		ys = y <<< k;
		x0 = 32'(xs >>> 16);
		y0 = 32'(ys >>> 16);
		fx = xs & 64'hFFFF;
		fy = ys & 64'hFFFF;
		top = lerp_q16(gradient_dot(x0, y0, fx, fy),
			gradient_dot(x0 + 1, y0, fx - 65536, fy), fx);
		bot = lerp_q16(gradient_dot(x0, y0 + 1, fx, fy - 65536),
			gradient_dot(x0 + 1, y0 + 1, fx - 65536, fy - 65536), fx);
		return (lerp_q16(top, bot, fy) >>> 16) + 32768;
	endfunction

	function automatic logic [gno_pkg::OUT_W-1:0] fractal_noise(logic signed [31:0] x,
			logic signed [31:0] y);
		longint amp, total, weight, res;
		int unsigned n;
		n = (octaves_cfg > gno_pkg::MAX_OCTAVES_DEF) ? gno_pkg::MAX_OCTAVES_DEF : octaves_cfg;
		if (n == 0)
			return '0;
		amp = 4096;
		total = 0;
		weight = 0;
		for (int k = 0; k < n; k++) begin
			total += octave_noise(longint'(x), longint'(y), k) * amp;
			weight += amp;
			amp = (amp * longint'(persist_cfg)) >>> 12;
			// amplitude saturates at 2^40-1
			if (amp > ((longint'(1) << 40) - 1))
				amp = (longint'(1) << 40) - 1;
		end
		res = (total <= 0) ? 0 : total / weight;
		return (res > 65535) ? gno_pkg::OUT_MAX : gno_pkg::OUT_W'(res);
	endfunction

	task automatic report_mismatch(string what, logic [gno_pkg::OUT_W-1:0] got,
			logic [gno_pkg::OUT_W-1:0] want);
		$display("mismatch: %s got %0d want %0d", what, got, want);
		fails++;
	endtask

	// Driver: record accepted transactions, then decide what to drive next.
	always @(posedge clk or negedge arst_n) begin
		stim_item_t it;
		logic nxt_start, nxt_we;
		logic signed [gno_pkg::COORD_W-1:0] nxt_x, nxt_y;
		logic [gno_pkg::CFG_IDX_W-1:0] nxt_idx;
		logic [gno_pkg::CFG_DATA_W-1:0] nxt_data;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			quiet_cycles = 0;
			gap_left = 0;
		end else begin
			if (start && !busy)
				noise_expected.push_back(fractal_noise(x_coord, y_coord));
			if (cfg_we) begin
				// writes to unknown indexes are dropped
				if (cfg_idx == gno_pkg::REG_OCTAVE_COUNT)
					octaves_cfg = cfg_wdata[gno_pkg::CNT_W-1:0];
				else if (cfg_idx == gno_pkg::REG_PERSISTENCE)
					persist_cfg = cfg_wdata;
			end
			if (noise_expected.size() == 0 && !start && !cfg_we)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			nxt_start = 1'b0;
			nxt_we = 1'b0;
			nxt_x = x_coord;
			nxt_y = y_coord;
			nxt_idx = cfg_idx;
			nxt_data = cfg_wdata;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() > 0) begin
				it = pending_items[0];
				case (it.kind)
					IT_SAMPLE: begin
						nxt_start = 1'b1;
						nxt_x = it.x;
						nxt_y = it.y;
						gap_left = $urandom_range(0, it.max_gap);
						void'(pending_items.pop_front());
					end
					IT_WRITE: if (quiet_cycles >= IDLE_CYCLES) begin
						nxt_we = 1'b1;
						nxt_idx = it.idx;
						nxt_data = it.data;
						void'(pending_items.pop_front());
					end
					default: if (quiet_cycles >= IDLE_CYCLES)
						void'(pending_items.pop_front());
				endcase
			end
			start <= nxt_start;
			cfg_we <= nxt_we;
			x_coord <= nxt_x;
			y_coord <= nxt_y;
			cfg_idx <= nxt_idx;
			cfg_wdata <= nxt_data;
		end
	end

	// Monitor: results cannot be held off, so check every done strobe.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (noise_expected.size() == 0)
				report_mismatch("unexpected result", noise_value, '0);
			else if (noise_value !== noise_expected[0])
				report_mismatch("noise_value", noise_value, noise_expected.pop_front());
			else
				void'(noise_expected.pop_front());
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			stall_cycles = 0;
		else if (++stall_cycles >= WATCHDOG_MAX) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic add_point(logic [31:0] x, logic [31:0] y, int max_gap);
		pending_items.push_back('{IT_SAMPLE, x, y, '0, '0, max_gap});
	endtask

	task automatic add_write(logic [gno_pkg::CFG_IDX_W-1:0] idx,
			logic [gno_pkg::CFG_DATA_W-1:0] data);
		pending_items.push_back('{IT_WRITE, '0, '0, idx, data, 0});
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(0, 3))
			0, 1: return $urandom;
			// a few lattice cells around the origin
			2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
			default: return $urandom_range(0, 1) ? 32'h7FFF_0000 + $urandom_range(0, 32'hFFFF)
				: 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
		endcase
	endfunction

	initial begin
		int unsigned oct, pers;
		// directed: reset settings, field extremes, lattice wrap
		add_point(32'h0000_0000, 32'h0000_0000, 4);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		add_point(32'h8000_0000, 32'h8000_0000, 0);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 2);
		add_point(32'hFFFF_FFFF, 32'h0000_FFFF, 1);
		add_point(32'h0001_8000, 32'hFFFE_8000, 3);
		// eight octaves at full persistence: wrap and amplitude cap
		add_write(gno_pkg::REG_OCTAVE_COUNT, 16'd8);
		add_write(gno_pkg::REG_PERSISTENCE, 16'hFFFF);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
		add_point(32'hFFFF_0000, 32'h0000_FFFF, 0);
		add_point(32'h1234_5678, 32'h9ABC_DEF0, 0);
		// count beyond the limit, upper data bits ignored; unknown indexes dropped
		add_write(gno_pkg::REG_OCTAVE_COUNT, 16'hFFFF);
		add_write(2'd2, 16'h0000);
		add_write(2'd3, 16'hFFFF);
		add_point(32'h0003_4000, 32'hFFF0_1234, 1);
		add_point(32'h8000_0000, 32'h0000_0000, 0);
		// zero persistence, then zero octaves
		add_write(gno_pkg::REG_PERSISTENCE, 16'd0);
		add_point(32'h0002_8000, 32'h0005_C000, 2);
		add_write(gno_pkg::REG_OCTAVE_COUNT, 16'd0);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		add_point(32'h0000_0000, 32'h8000_0000, 0);
		// random phases with varying settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: oct = 1;
				1: oct = 8;
				2: oct = 15;
				default: oct = $urandom_range(0, 15);
			endcase
			case ($urandom_range(0, 3))
				0: pers = 0;
				1: pers = 16'hFFFF;
				2: pers = 4096;
				default: pers = $urandom_range(0, 16'hFFFF);
			endcase
			add_write(gno_pkg::REG_OCTAVE_COUNT,
				gno_pkg::CFG_DATA_W'(oct | ($urandom & 32'hFFF0)));
			add_write(gno_pkg::REG_PERSISTENCE, gno_pkg::CFG_DATA_W'(pers));
			if ($urandom_range(0, 3) == 0)
				add_write(2'd2 + 2'($urandom_range(0, 1)), 16'($urandom));
			for (int i = 0; i < 50; i++) begin
				// hold off once mid-phase until the pipeline drains
				if (ph == 3 && i == 25)
					pending_items.push_back('{IT_DRAIN, '0, '0, '0, '0, 0});
				add_point(random_coord(), random_coord(), (ph % 3 == 1) ? 0 : 4);
			end
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_items.size() != 0 || start || noise_expected.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gno_pkg.sv
rtl/gno_octave_cell.sv
rtl/gno_div_cell.sv
rtl/gradient_noise_octaves.sv
tb/sv/gradient_noise_octaves_test.sv
